[sv/stip_pkg.sv]
package stip_pkg;

    // Beat widths
    localparam int IN_W   = 8;
    localparam int VAL_W  = 64;
    localparam int OFF_W  = 16;
    localparam int BASE_W = 6;
    localparam int OUT_W  = 88;

    // Result beat layout, lowest bit up
    localparam int OUT_VAL_LO = 0;
    localparam int OUT_ERR    = 64;
    localparam int OUT_FOUND  = 65;
    localparam int OUT_OFF_LO = 66;
    localparam int OUT_PAD_W  = OUT_W - (OUT_OFF_LO + OFF_W);

    // Register indexes (byte address 4*index)
    localparam logic REG_NUMBER_BASE   = 1'b0;
    localparam logic REG_SIGNED_RESULT = 1'b1;

    localparam logic [BASE_W-1:0] BASE_RESET   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_DEC     = 6'd10;
    localparam logic [BASE_W-1:0] BASE_OCT     = 6'd8;
    localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_W-1:0] DIGIT_NONE   = 6'd63;

    // Characters of interest
    localparam logic [IN_W-1:0] CH_SPACE = 8'h20;
    localparam logic [IN_W-1:0] CH_TAB   = 8'h09;
    localparam logic [IN_W-1:0] CH_CR    = 8'h0d;
    localparam logic [IN_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [IN_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [IN_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [IN_W-1:0] CH_NINE  = 8'h39;
    localparam logic [IN_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [IN_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [IN_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [IN_W-1:0] CH_Z_LO  = 8'h7a;
    localparam logic [IN_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [IN_W-1:0] CH_Z_UP  = 8'h5a;

    localparam logic [VAL_W-1:0] SIGNED_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [VAL_W-1:0] SIGNED_MIN = 64'h8000_0000_0000_0000;
    localparam logic [VAL_W-1:0] ALL_ONES   = 64'hffff_ffff_ffff_ffff;

    // Multiply-add result handed back to the parser
    typedef struct packed {
        logic             digit_ok;
        logic             overflow;
        logic [VAL_W-1:0] acc;
    } mac_res_t;

    // Raw digit value 0..35, DIGIT_NONE for anything else
    function automatic logic [BASE_W-1:0] digit_raw(input logic [IN_W-1:0] c);
        logic [IN_W-1:0] d;
        d = IN_W'(DIGIT_NONE);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
            d = c - CH_A_LO + 8'd10;
        end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
            d = c - CH_A_UP + 8'd10;
        end
        return d[BASE_W-1:0];
    endfunction

endpackage

[sv/stip_mac.sv]
module stip_mac (
    input  logic [stip_pkg::VAL_W-1:0]  acc,
    input  logic [stip_pkg::BASE_W-1:0] base,
    input  logic [stip_pkg::IN_W-1:0]   char_code,
    output stip_pkg::mac_res_t          res
);

    localparam int PROD_W = stip_pkg::VAL_W + stip_pkg::BASE_W;

    logic [stip_pkg::BASE_W-1:0] base_eff;
    logic [stip_pkg::BASE_W-1:0] raw;
    logic [PROD_W-1:0]           sum;

    // base 0 falls back to decimal
    assign base_eff = (base == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC : base;
    assign raw      = stip_pkg::digit_raw(char_code);

    // acc * base + digit; anything at or above 2^64 is an overflow
    assign sum = PROD_W'(acc) * PROD_W'(base_eff) + PROD_W'(raw);

    assign res.digit_ok = (raw < base_eff);
    assign res.overflow = |sum[PROD_W-1:stip_pkg::VAL_W];
    assign res.acc      = sum[stip_pkg::VAL_W-1:0];

endmodule

[sv/string_to_integer_parser.sv]
// String to integer parser, strtoll / strtoull style.
// s_ channel: one byte of the string per beat in s_tdata, s_tlast on the
// final byte. m_ channel: one result beat per string, issued after the
// tlast beat. Leading blanks and one sign are taken, then a base prefix
// (0x, or leading 0 for octal in auto mode) and digits up to the first
// non-digit; later bytes are ignored until tlast.
// Timing: a byte waits in the input register while digit decode and a
// 64x6 multiply-add work out the parse state, registered as it leaves.
// A result goes to the output register driving m_tvalid as its tlast
// byte leaves the input register. One byte is taken per cycle unless the
// parse stage stalls; the accumulator's multiply-add loop sets the rate.
// A stalled result stays in the output register; bytes keep flowing until
// the next tlast beat reaches the parse stage, which then waits for it.
// Reset clears the parse state, empties both registers and loads base 10,
// signed mode. Configuration through the APB port only while idle.
module string_to_integer_parser #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // s_tdata: [7:0] char_code; s_tlast: last_char
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,
    input  logic                      s_tlast,
    // m_tdata: [63:0] value_bits, [64] range_error, [65] digits_found,
    //          [81:66] end_offset, [87:82] zero
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [stip_pkg::OUT_W-1:0] m_tdata,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_ZEROX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // Config
    logic [stip_pkg::BASE_W-1:0] base_reg;
    logic                        signed_reg;

    // Input register
    logic                        in_valid_reg, in_valid_next;
    logic [stip_pkg::IN_W-1:0]   in_char_reg;
    logic                        in_last_reg;

    // Parse state
    phase_t                      phase_reg, phase_next;
    logic [stip_pkg::VAL_W-1:0]  acc_reg, acc_next;
    logic                        ovf_reg, ovf_next;
    logic                        minus_reg, minus_next;
    logic [stip_pkg::BASE_W-1:0] ebase_reg, ebase_next;
    logic [OFFSET_BITS-1:0]      pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]      dend_reg, dend_next;

    // Output register, raw snapshot of the finished string
    logic                        out_valid_reg, out_valid_next;
    logic [stip_pkg::VAL_W-1:0]  out_acc_reg;
    logic                        out_ovf_reg;
    logic                        out_minus_reg;
    logic                        out_signed_reg;
    logic [OFFSET_BITS-1:0]      out_dend_reg;

    logic                        advance;
    logic                        cfg_wr;
    logic                        take;
    logic                        start;
    logic [stip_pkg::BASE_W-1:0] dig_base;
    logic [stip_pkg::BASE_W-1:0] start_base;
    logic [stip_pkg::BASE_W-1:0] raw;
    logic [OFFSET_BITS-1:0]      pos_inc;
    logic                        is_blank;
    stip_pkg::mac_res_t          mac;

    logic [stip_pkg::VAL_W-1:0]  val;
    logic                        err;

    // Handshakes
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    // Register read
    always_comb begin
        unique case (paddr[2])
            stip_pkg::REG_NUMBER_BASE:   prdata = {26'd0, base_reg};
            stip_pkg::REG_SIGNED_RESULT: prdata = {31'd0, signed_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    assign raw      = stip_pkg::digit_raw(in_char_reg);
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign is_blank = (in_char_reg == stip_pkg::CH_SPACE) ||
                      (in_char_reg >= stip_pkg::CH_TAB && in_char_reg <= stip_pkg::CH_CR);
    assign start_base = (base_reg == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC : base_reg;

    // Decide whether this byte is a digit candidate and in which base
    always_comb begin
        take     = 1'b0;
        start    = 1'b0;
        dig_base = ebase_reg;
        unique case (phase_reg)
            PH_SPACE: begin
                if (!is_blank && in_char_reg != stip_pkg::CH_PLUS &&
                    in_char_reg != stip_pkg::CH_MINUS) begin
                    start = 1'b1;
                end
            end
            PH_SIGNED: start = 1'b1;
            PH_ZERO: begin
                if (in_char_reg != stip_pkg::CH_X_LO && in_char_reg != stip_pkg::CH_X_UP) begin
                    take = 1'b1;
                    if (ebase_reg == stip_pkg::BASE_AUTO) begin
                        dig_base = (raw < stip_pkg::BASE_OCT) ? stip_pkg::BASE_OCT
                                                              : stip_pkg::BASE_DEC;
                    end
                end
            end
            PH_ZEROX: begin
                take     = (raw < stip_pkg::BASE_HEX);
                dig_base = stip_pkg::BASE_HEX;
            end
            PH_DIGITS: take = 1'b1;
            default: ;
        endcase
        // A leading 0 in auto or hex mode waits for a possible prefix
        if (start && !(in_char_reg == stip_pkg::CH_ZERO &&
                       (base_reg == stip_pkg::BASE_AUTO || base_reg == stip_pkg::BASE_HEX))) begin
            take     = 1'b1;
            dig_base = start_base;
        end
    end

    stip_mac u_mac (
        .acc       (acc_reg),
        .base      (dig_base),
        .char_code (in_char_reg),
        .res       (mac)
    );

    // Next parse state for the byte in the input register
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        minus_next = minus_reg;
        ebase_next = ebase_reg;
        pos_next   = pos_inc;
        dend_next  = dend_reg;
        if (phase_reg == PH_SPACE && !is_blank && (in_char_reg == stip_pkg::CH_PLUS ||
                                                   in_char_reg == stip_pkg::CH_MINUS)) begin
            minus_next = (in_char_reg == stip_pkg::CH_MINUS);
            phase_next = PH_SIGNED;
        end
        if (start) begin
            ebase_next = base_reg;
            if (!take) begin
                phase_next = PH_ZERO;
                dend_next  = pos_inc;
            end
        end
        if (phase_reg == PH_ZERO && !take) begin
            phase_next = PH_ZEROX;
        end
        if (phase_reg == PH_ZEROX && !take) begin
            phase_next = PH_DONE;
        end
        if (take) begin
            ebase_next = dig_base;
            if (!mac.digit_ok) begin
                phase_next = PH_DONE;
            end else begin
                phase_next = PH_DIGITS;
                dend_next  = pos_inc;
                if (mac.overflow) begin
                    ovf_next = 1'b1;
                end else begin
                    acc_next = mac.acc;
                end
            end
        end
    end

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = (advance && in_last_reg) ? 1'b1 :
                            (m_tready ? 1'b0 : out_valid_reg);

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= stip_pkg::BASE_RESET;
            signed_reg    <= 1'b1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SPACE;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            minus_reg     <= 1'b0;
            ebase_reg     <= '0;
            pos_reg       <= '0;
            dend_reg      <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == stip_pkg::REG_NUMBER_BASE) begin
                    base_reg <= pwdata[stip_pkg::BASE_W-1:0];
                end else begin
                    signed_reg <= pwdata[0];
                end
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (s_tvalid && s_tready) begin
                in_char_reg <= s_tdata;
                in_last_reg <= s_tlast;
            end
            if (advance) begin
                if (in_last_reg) begin
                    out_acc_reg    <= acc_next;
                    out_ovf_reg    <= ovf_next;
                    out_minus_reg  <= minus_next;
                    out_signed_reg <= signed_reg;
                    out_dend_reg   <= dend_next;
                    phase_reg      <= PH_SPACE;
                    acc_reg        <= '0;
                    ovf_reg        <= 1'b0;
                    minus_reg      <= 1'b0;
                    ebase_reg      <= '0;
                    pos_reg        <= '0;
                    dend_reg       <= '0;
                end else begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    ovf_reg   <= ovf_next;
                    minus_reg <= minus_next;
                    ebase_reg <= ebase_next;
                    pos_reg   <= pos_next;
                    dend_reg  <= dend_next;
                end
            end
        end
    end

    // Saturation and sign applied to the held result
    always_comb begin
        if (out_signed_reg) begin
            err = out_ovf_reg ||
                  (!out_minus_reg && out_acc_reg[stip_pkg::VAL_W-1]) ||
                  (out_minus_reg && out_acc_reg[stip_pkg::VAL_W-1] &&
                   (|out_acc_reg[stip_pkg::VAL_W-2:0]));
            if (err) begin
                val = out_minus_reg ? stip_pkg::SIGNED_MIN : stip_pkg::SIGNED_MAX;
            end else begin
                val = out_minus_reg ? (stip_pkg::VAL_W'(0) - out_acc_reg) : out_acc_reg;
            end
        end else begin
            err = out_ovf_reg;
            if (err) begin
                val = stip_pkg::ALL_ONES;
            end else begin
                val = out_minus_reg ? (stip_pkg::VAL_W'(0) - out_acc_reg) : out_acc_reg;
            end
        end
    end

    assign m_tdata = {{stip_pkg::OUT_PAD_W{1'b0}},
                      stip_pkg::OFF_W'(out_dend_reg),
                      (out_dend_reg != '0),
                      err,
                      val};

endmodule

[sv/stip_checker.sv]
module stip_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [stip_pkg::OUT_W-1:0] m_tdata
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // No result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With the output register empty the input side never stalls
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A string without digits reports zero everywhere
    a_no_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[stip_pkg::OUT_FOUND] |->
            m_tdata[stip_pkg::OUT_ERR-1:0] == '0 && !m_tdata[stip_pkg::OUT_ERR] &&
            m_tdata[stip_pkg::OUT_OFF_LO+stip_pkg::OFF_W-1:stip_pkg::OUT_OFF_LO] == '0)
        else $error("empty parse with nonzero fields");

endmodule

bind string_to_integer_parser stip_checker u_stip_checker (.*);

[sim/tb.sv]
module tb;
    import stip_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned NOT_A_DIGIT = 64;
    localparam int unsigned PHASES      = 10;
    localparam int unsigned PHASE_BYTES = 125;
    localparam logic [OFF_W-1:0] POS_MAX = '1;

    // Random phases: number base and signed mode per phase (the last one runs without idling)
    localparam int unsigned PHASE_BASE[PHASES] = '{10, 0, 16, 36, 0, 8, 2, 63, 1, 10};
    localparam bit          PHASE_SGN[PHASES]  = '{1, 1, 0, 1, 0, 0, 1, 0, 1, 1};

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             err;
        logic             found;
        logic [OFF_W-1:0] offset;
    } parse_result_t;

    typedef struct {
        string         text;
        int unsigned   base;
        bit            sgn;
        int unsigned   lead_zeros;
        bit            typed;
        parse_result_t want;
    } stim_row_t;

    typedef enum logic [2:0] {
        SKIP_BLANKS, AFTER_SIGN, SEEN_ZERO, SEEN_ZERO_X, IN_DIGITS, PAST_DIGITS
    } parse_phase_e;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;   // [7:0] char_code
    logic              s_tlast;   // last_char
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;   // [63:0] value_bits, [64] range_error, [65] digits_found,
                                  // [81:66] end_offset, [87:82] zero
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    string_to_integer_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mirror of the configuration and of the per-string parse state
    logic [BASE_W-1:0] cfg_base   = BASE_RESET;
    logic              cfg_signed = 1'b1;

    parse_phase_e      prs_phase = SKIP_BLANKS;
    logic [VAL_W-1:0]  prs_acc   = '0;
    logic              prs_ovf   = 1'b0;
    logic              prs_neg   = 1'b0;
    logic [BASE_W-1:0] prs_base  = '0;
    logic [OFF_W-1:0]  prs_pos   = '0;
    logic [OFF_W-1:0]  prs_end   = '0;

    parse_result_t     pending_results[$];
    parse_result_t     typed_result;
    bit                typed_valid = 1'b0;
    int unsigned       mismatches  = 0;
    bit                tx_idling   = 1'b1;
    bit                rx_idling   = 1'b1;
    bit                hold_request = 1'b0;
    stim_row_t         dir_rows[$];

    function automatic parse_result_t make_result(input logic [VAL_W-1:0] v, input logic e,
                                                  input logic f, input logic [OFF_W-1:0] o);
        parse_result_t r;
        r.value  = v;
        r.err    = e;
        r.found  = f;
        r.offset = o;
        return r;
    endfunction

    // Digit value of a character, NOT_A_DIGIT when outside the radix
    function automatic int unsigned char_digit(input logic [7:0] c, input int unsigned radix);
        int unsigned d;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
            d = c - CH_A_LO + 10;
        end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
            d = c - CH_A_UP + 10;
        end else begin
            return NOT_A_DIGIT;
        end
        return (d < radix) ? d : NOT_A_DIGIT;
    endfunction

    function automatic void accumulate_char(input logic [7:0] c);
        int unsigned radix;
        int unsigned d;
        radix = (prs_base != 0) ? int'(prs_base) : 10;
        d = char_digit(c, radix);
        if (d == NOT_A_DIGIT) begin
            prs_phase = PAST_DIGITS;
            return;
        end
        // sticky overflow; the accumulator freezes once it would wrap
        if (prs_acc > (ALL_ONES - 64'(d)) / 64'(radix)) begin
            prs_ovf = 1'b1;
        end else begin
            prs_acc = prs_acc * 64'(radix) + 64'(d);
        end
        prs_end = prs_pos;
    endfunction

    function automatic void begin_digits(input logic [7:0] c);
        prs_base = cfg_base;
        // a leading zero may still turn into a hex or octal prefix
        if (c == CH_ZERO && (prs_base == BASE_AUTO || prs_base == BASE_HEX)) begin
            prs_end   = prs_pos;
            prs_phase = SEEN_ZERO;
            return;
        end
        if (prs_base == BASE_AUTO) prs_base = BASE_DEC;
        prs_phase = IN_DIGITS;
        accumulate_char(c);
    endfunction

    // Advance the parse by one byte; returns 1 with the result on the final byte
    function automatic bit feed_char(input logic [7:0] c, input logic last,
                                     output parse_result_t r);
        logic [VAL_W-1:0] v;
        logic             e;
        if (prs_pos != POS_MAX) prs_pos++;
        case (prs_phase)
            SKIP_BLANKS: begin
                if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        prs_neg   = (c == CH_MINUS);
                        prs_phase = AFTER_SIGN;
                    end else begin
                        begin_digits(c);
                    end
                end
            end
            AFTER_SIGN: begin
                begin_digits(c);
            end
            SEEN_ZERO: begin
                if (c == CH_X_LO || c == CH_X_UP) begin
                    prs_phase = SEEN_ZERO_X;
                end else begin
                    if (prs_base == BASE_AUTO)
                        prs_base = (char_digit(c, 8) != NOT_A_DIGIT) ? BASE_OCT : BASE_DEC;
                    prs_phase = IN_DIGITS;
                    accumulate_char(c);
                end
            end
            SEEN_ZERO_X: begin
                // the x counts only when a hex digit follows it
                if (char_digit(c, 16) != NOT_A_DIGIT) begin
                    prs_base  = BASE_HEX;
                    prs_phase = IN_DIGITS;
                    accumulate_char(c);
                end else begin
                    prs_phase = PAST_DIGITS;
                end
            end
            IN_DIGITS: begin
                accumulate_char(c);
            end
            default: ;
        endcase
        if (!last) return 1'b0;

        // saturation and sign
        v = prs_acc;
        e = 1'b0;
        if (cfg_signed) begin
            if (prs_ovf || (!prs_neg && v > SIGNED_MAX) || (prs_neg && v > SIGNED_MIN)) begin
                e = 1'b1;
                v = prs_neg ? SIGNED_MIN : SIGNED_MAX;
            end else if (prs_neg) begin
                v = 64'd0 - v;
            end
        end else begin
            if (prs_ovf) begin
                e = 1'b1;
                v = ALL_ONES;
            end else if (prs_neg) begin
                v = 64'd0 - v;
            end
        end
        r = make_result(v, e, prs_end != 0, prs_end);

        prs_phase = SKIP_BLANKS;
        prs_acc   = '0;
        prs_ovf   = 1'b0;
        prs_neg   = 1'b0;
        prs_base  = '0;
        prs_pos   = '0;
        prs_end   = '0;
        return 1'b1;
    endfunction

    // Offer one byte, with an optional idle burst ahead of it
    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned   gap;
        parse_result_t r;
        if (tx_idling && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (feed_char(c, last, r)) begin
            pending_results.push_back(typed_valid ? typed_result : r);
            typed_valid = 1'b0;
        end
    endtask

    // Stop offering bytes and let the block go idle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_NUMBER_BASE) begin
            cfg_base = val[BASE_W-1:0];
        end else begin
            cfg_signed = val[0];
        end
        @(posedge aclk);
    endtask

    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10) return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + 8'(d - 10);
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: begin
                case ($urandom_range(0, 7))
                    0: return CH_SPACE;
                    1: return CH_PLUS;
                    2: return CH_MINUS;
                    3: return CH_ZERO;
                    4: return CH_X_LO;
                    5: return CH_X_UP;
                    6: return CH_TAB;
                    default: return CH_CR;
                endcase
            end
            2: return 8'($urandom_range(0, 127));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    // One random string under the current base: mostly well formed, some noise
    task automatic send_random_string(inout int unsigned counted);
        logic [7:0]       s[$];
        logic [7:0]       tmp[$];
        logic [VAL_W-1:0] v;
        int unsigned      radix;
        int unsigned      nd;
        int unsigned      tail;
        tail = 0;
        if ($urandom_range(0, 99) < 15) begin
            nd = $urandom_range(1, 6);
            repeat (nd) s.push_back(noise_char());
        end else begin
            nd = $urandom_range(0, 3);
            repeat (nd) s.push_back($urandom_range(0, 6) == 0 ? CH_SPACE
                                                              : 8'($urandom_range(9, 13)));
            case ($urandom_range(0, 3))
                0: s.push_back(CH_PLUS);
                1: s.push_back(CH_MINUS);
                default: ;
            endcase
            radix = cfg_base;
            if (cfg_base == BASE_AUTO) begin
                case ($urandom_range(0, 2))
                    0: radix = 10;
                    1: begin
                        radix = 8;
                        s.push_back(CH_ZERO);
                    end
                    default: begin
                        radix = 16;
                        s.push_back(CH_ZERO);
                        s.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
                    end
                endcase
            end else if (cfg_base == BASE_HEX && $urandom_range(0, 1)) begin
                s.push_back(CH_ZERO);
                s.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
            end
            if (radix > 36) radix = 36;
            case ($urandom_range(0, 7))
                4, 5: begin
                    if (radix < 2) begin
                        nd = $urandom_range(1, 6);
                        repeat (nd) s.push_back(CH_ZERO);
                    end else begin
                        // values around the saturation limits, written in the radix
                        case ($urandom_range(0, 3))
                            0: v = {$urandom, $urandom};
                            1: v = SIGNED_MAX + 64'($urandom_range(0, 4)) - 64'd2;
                            2: v = ALL_ONES - 64'($urandom_range(0, 3));
                            default: v = 64'($urandom_range(0, 1000));
                        endcase
                        do begin
                            tmp.push_front(digit_char(int'(v % 64'(radix))));
                            v = v / 64'(radix);
                        end while (v != 0);
                        foreach (tmp[i]) s.push_back(tmp[i]);
                        if ($urandom_range(0, 2) == 0)
                            s.push_back(digit_char($urandom_range(0, radix - 1)));
                    end
                end
                6: begin
                    nd = $urandom_range(15, 30);
                    repeat (nd) s.push_back(digit_char($urandom_range(0, radix - 1)));
                end
                7: ;  // prefix or sign with no digits behind it
                default: begin
                    nd = $urandom_range(1, 6);
                    repeat (nd) s.push_back(digit_char($urandom_range(0, radix - 1)));
                end
            endcase
            tail = $urandom_range(0, 2);
            repeat (tail) s.push_back(noise_char());
        end
        if (s.size() == 0) s.push_back(noise_char());
        foreach (s[i]) send_char(s[i], i == s.size() - 1);
        counted += s.size() - tail;
    endtask

    // Result side: idle bursts, plus one long hold-off on request
    initial begin : result_sink
        int unsigned n;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end else if (rx_idling && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic note_mismatch(input string what, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endtask

    // Compare every result beat with the oldest expectation
    always @(posedge aclk) begin
        parse_result_t want;
        parse_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = make_result(m_tdata[OUT_VAL_LO +: VAL_W], m_tdata[OUT_ERR],
                              m_tdata[OUT_FOUND], m_tdata[OUT_OFF_LO +: OFF_W]);
            if (pending_results.size() == 0) begin
                note_mismatch("result beat with nothing pending", '0, got.value);
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value) note_mismatch("value_bits", want.value, got.value);
                if (got.err !== want.err) note_mismatch("range_error", want.err, got.err);
                if (got.found !== want.found)
                    note_mismatch("digits_found", want.found, got.found);
                if (got.offset !== want.offset)
                    note_mismatch("end_offset", want.offset, got.offset);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned counted;
        int unsigned len;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        // text, base, signed, leading zeros, typed, expected result
        dir_rows.push_back('{"x", 10, 1, 0, 1, make_result(0, 0, 0, 0)});
        dir_rows.push_back('{"  +123abc", 10, 1, 0, 1, make_result(123, 0, 1, 6)});
        dir_rows.push_back('{"9223372036854775807", 10, 1, 0, 1,
                             make_result(SIGNED_MAX, 0, 1, 19)});
        dir_rows.push_back('{"9223372036854775808", 10, 1, 0, 1,
                             make_result(SIGNED_MAX, 1, 1, 19)});
        dir_rows.push_back('{"-9223372036854775808", 10, 1, 0, 1,
                             make_result(SIGNED_MIN, 0, 1, 20)});
        dir_rows.push_back('{"-9223372036854775809", 10, 1, 0, 1,
                             make_result(SIGNED_MIN, 1, 1, 20)});
        dir_rows.push_back('{"\011\012\013\014\015 42", 10, 1, 0, 1, make_result(42, 0, 1, 8)});
        dir_rows.push_back('{"- 5", 10, 1, 0, 1, make_result(0, 0, 0, 0)});
        dir_rows.push_back('{"+", 10, 1, 0, 1, make_result(0, 0, 0, 0)});
        dir_rows.push_back('{"0x5", 10, 1, 0, 1, make_result(0, 0, 1, 1)});
        dir_rows.push_back('{"\377 7", 10, 1, 0, 1, make_result(0, 0, 0, 0)});
        // a run of leading zeros counts toward the end offset
        dir_rows.push_back('{"12", 10, 1, 40, 1, make_result(12, 0, 1, 42)});
        dir_rows.push_back('{"18446744073709551615", 10, 0, 0, 1,
                             make_result(ALL_ONES, 0, 1, 20)});
        dir_rows.push_back('{"18446744073709551616", 10, 0, 0, 1,
                             make_result(ALL_ONES, 1, 1, 20)});
        dir_rows.push_back('{"-1", 10, 0, 0, 1, make_result(ALL_ONES, 0, 1, 2)});
        dir_rows.push_back('{"ffffffffffffffffff", 16, 0, 0, 1,
                             make_result(ALL_ONES, 1, 1, 18)});
        dir_rows.push_back('{"0x", 16, 1, 0, 1, make_result(0, 0, 1, 1)});
        dir_rows.push_back('{"0X1f", 16, 1, 0, 1, make_result(31, 0, 1, 4)});
        dir_rows.push_back('{"-0x8000000000000000", 16, 1, 0, 1,
                             make_result(SIGNED_MIN, 0, 1, 19)});
        dir_rows.push_back('{"0xg", 0, 1, 0, 1, make_result(0, 0, 1, 1)});
        dir_rows.push_back('{"017", 0, 1, 0, 1, make_result(15, 0, 1, 3)});
        dir_rows.push_back('{"019", 0, 1, 0, 1, make_result(1, 0, 1, 2)});
        dir_rows.push_back('{"08", 0, 1, 0, 1, make_result(8, 0, 1, 2)});
        dir_rows.push_back('{"0", 0, 1, 0, 1, make_result(0, 0, 1, 1)});
        dir_rows.push_back('{"zZ", 36, 1, 0, 1, make_result(1295, 0, 1, 2)});
        dir_rows.push_back('{"Zz9", 63, 1, 0, 0, '0});
        dir_rows.push_back('{"1", 1, 1, 0, 1, make_result(0, 0, 0, 0)});
        dir_rows.push_back('{"0012", 1, 1, 0, 0, '0});
        dir_rows.push_back('{"-101", 2, 0, 0, 0, '0});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (dir_rows[i]) begin
            if (BASE_W'(dir_rows[i].base) != cfg_base || dir_rows[i].sgn != cfg_signed) begin
                drain_results();
                write_reg(REG_NUMBER_BASE, 32'(dir_rows[i].base));
                write_reg(REG_SIGNED_RESULT, 32'(dir_rows[i].sgn));
            end
            typed_valid  = dir_rows[i].typed;
            typed_result = dir_rows[i].want;
            tx_idling    = (dir_rows[i].lead_zeros == 0);
            repeat (dir_rows[i].lead_zeros) send_char(CH_ZERO, 1'b0);
            tx_idling = 1'b1;
            len = dir_rows[i].text.len();
            for (int k = 0; k < len; k++)
                send_char(dir_rows[i].text[k], k == len - 1);
        end

        // random strings, one base and sign setting per phase
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_reg(REG_NUMBER_BASE, 32'(PHASE_BASE[p]));
            write_reg(REG_SIGNED_RESULT, 32'(PHASE_SGN[p]));
            tx_idling = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idling = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            // block the result side long enough for the input to back up
            if (p == 1) hold_request = 1'b1;
            counted = 0;
            while (counted < PHASE_BYTES) send_random_string(counted);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
